// ===== rtl/adw_pkg.sv =====
// ----------------------------------------------------------------------------
// adw_pkg
// Types and constants shared by the archive directory walker modules.
// ----------------------------------------------------------------------------
package adw_pkg;

    // Walk phases, one-hot coded.
    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_FIXED  = 5'b00100,
        PH_NAME   = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    // Result status codes.
    localparam logic [1:0] ST_MEMBER  = 2'd0;
    localparam logic [1:0] ST_SUMMARY = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    // Reject reason codes.
    localparam logic [3:0] RS_NONE     = 4'd0;
    localparam logic [3:0] RS_SHORT    = 4'd1;
    localparam logic [3:0] RS_TAG      = 4'd2;
    localparam logic [3:0] RS_DIRZERO  = 4'd3;
    localparam logic [3:0] RS_COUNT    = 4'd4;
    localparam logic [3:0] RS_OVERFLOW = 4'd5;
    localparam logic [3:0] RS_CHAIN    = 4'd6;
    localparam logic [3:0] RS_RANGE    = 4'd7;
    localparam logic [3:0] RS_INDIR    = 4'd8;
    localparam logic [3:0] RS_NAME     = 4'd9;
    localparam logic [3:0] RS_EMPTY    = 4'd10;
    localparam logic [3:0] RS_ADJACENT = 4'd11;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SPAN = 2'd0;
    localparam logic [1:0] CFG_BASE = 2'd1;

    // Layout constants.
    localparam int HDR_LEN   = 14;
    localparam int FIXED_LEN = 26;
    localparam int MIN_REC   = 28;
    localparam int MIN_SPAN  = 47;
    localparam logic [15:0] HDR_TAG = 16'h000E;

    // One result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  reason;
        logic [15:0] member_count;
        logic [32:0] record_offset;
        logic [8:0]  record_length;
        logic [32:0] payload_offset;
        logic [30:0] packed_size;
        logic [30:0] unpacked_size;
        logic        method_byte;
        logic [31:0] timestamp;
        logic [31:0] image_extent;
        logic        last_result;
    } result_t;

endpackage

// ===== rtl/archive_directory_walker_unit.sv =====
// ----------------------------------------------------------------------------
// archive_directory_walker_unit
// Walks the header and directory of a disk image and reports its members.
// ----------------------------------------------------------------------------
// Usage: image bytes enter one per item on the in channel, in file order,
// with start_flag set on the byte at offset 0. Each accepted member gives a
// result item; the walk closes with one summary or one reject item, marked
// by last_result. Bytes after the end are ignored until the next start.
// The cfg channel writes image_span (index 0) and image_base (index 1); it
// is always ready. The user must write it only while the walker is idle;
// the block does not enforce this. Throughput: one byte per cycle while
// in_ready is high. A byte is processed in the cycle it is accepted; its
// results go to a four-entry result queue, and one byte can cause two
// results (member and summary). in_ready is held low while fewer than two
// entries are free. When the receiver stalls the queue fills and input
// stops after at most four waiting results.
// Reset clears the walk to idle, empties the queue and zeroes both
// configuration registers.
// ----------------------------------------------------------------------------
module archive_directory_walker_unit #(
    parameter int MAX_NAME_LENGTH = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  image_byte,
    input  logic        start_flag,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  reason,
    output logic [15:0] member_count,
    output logic [32:0] record_offset,
    output logic [8:0]  record_length,
    output logic [32:0] payload_offset,
    output logic [30:0] packed_size,
    output logic [30:0] unpacked_size,
    output logic        method_byte,
    output logic [31:0] timestamp,
    output logic [31:0] image_extent,
    output logic        last_result
);
    import adw_pkg::*;

    logic [31:0] span_reg, base_reg;
    logic [1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [2:0]  cnt_reg, cnt_next;
    result_t     q_reg [0:3];
    result_t     res0, res1, head_item;
    logic [1:0]  res_n;
    logic        fire, pop;

    assign cfg_ready = 1'b1;
    assign in_ready  = (cnt_reg <= 3'd2);
    assign fire      = in_valid && in_ready;
    assign out_valid = (cnt_reg != 3'd0);
    assign pop       = out_valid && out_ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= '0;
            base_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_SPAN) span_reg <= cfg_data;
            if (cfg_index == CFG_BASE) base_reg <= cfg_data;
        end
    end

    adw_walk #(
        .MAX_NAME_LENGTH (MAX_NAME_LENGTH)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .image_byte (image_byte),
        .start_flag (start_flag),
        .span       (span_reg),
        .base       (base_reg),
        .res_n      (res_n),
        .res0       (res0),
        .res1       (res1)
    );

    // Result queue pointers.
    always_comb
    begin
        head_next = head_reg + 2'(pop);
        tail_next = tail_reg + res_n;
        cnt_next  = cnt_reg + 3'(res_n) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (res_n != 2'd0) q_reg[tail_reg] <= res0;
        if (res_n == 2'd2) q_reg[tail_reg + 2'd1] <= res1;
    end

    assign head_item      = q_reg[head_reg];
    assign status         = head_item.status;
    assign reason         = head_item.reason;
    assign member_count   = head_item.member_count;
    assign record_offset  = head_item.record_offset;
    assign record_length  = head_item.record_length;
    assign payload_offset = head_item.payload_offset;
    assign packed_size    = head_item.packed_size;
    assign unpacked_size  = head_item.unpacked_size;
    assign method_byte    = head_item.method_byte;
    assign timestamp      = head_item.timestamp;
    assign image_extent   = head_item.image_extent;
    assign last_result    = head_item.last_result;

endmodule

// ===== rtl/adw_walk.sv =====
// ----------------------------------------------------------------------------
// adw_walk
// Per-byte walker: header checks, record capture and checks, result build.
// ----------------------------------------------------------------------------
module adw_walk #(
    parameter int MAX_NAME_LENGTH = 255
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [7:0]           image_byte,
    input  logic                 start_flag,
    input  logic [31:0]          span,
    input  logic [31:0]          base,
    output logic [1:0]           res_n,
    output adw_pkg::result_t     res0,
    output adw_pkg::result_t     res1
);
    import adw_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [16:0] pos_reg, pos_next;
    logic [15:0] dlen_reg, dlen_next;
    logic [15:0] acnt_reg, acnt_next;
    logic [16:0] rstart_reg, rstart_next;
    logic [8:0]  nlen_reg, nlen_next;
    logic [2:0]  nflag_reg, nflag_next;
    logic [15:0] done_reg, done_next;
    logic        fpv_reg, fpv_next;
    logic [31:0] fp_reg, fp_next;
    logic [32:0] fend_reg, fend_next;
    logic [7:0]  rb_reg [0:25];

    logic [4:0]  wr_idx;
    logic        rb_we;
    logic        cur_we;
    logic [16:0] k_w;
    logic [7:0]  cur [0:25];

    // Summary or the reject that replaces it at the end of a walk.
    function automatic result_t make_summary(input logic [15:0] n, input logic fpv,
                                             input logic [31:0] fp, input logic [15:0] dl,
                                             input logic [32:0] fe, input logic [31:0] sp);
        result_t r;
        logic [16:0] dend;
        r = '0;
        dend = 17'(dl) + 17'(HDR_LEN);
        r.last_result = 1'b1;
        if (n == 16'd0) begin
            r.status = ST_REJECT;
            r.reason = RS_EMPTY;
        end else if (!fpv || fp != 32'(dend)) begin
            r.status = ST_REJECT;
            r.reason = RS_ADJACENT;
        end else begin
            r.status = ST_SUMMARY;
            r.member_count = n;
            r.image_extent = (fe < {1'b0, sp}) ? fe[31:0] : sp;
        end
        return r;
    endfunction

    function automatic result_t make_reject(input logic [3:0] rsn);
        result_t r;
        r = '0;
        r.status = ST_REJECT;
        r.reason = rsn;
        r.last_result = 1'b1;
        return r;
    endfunction

    // Byte store write position and the view with the current byte merged in.
    // The byte is merged only where it is a header or fixed record byte.
    assign k_w = pos_reg - 17'(HDR_LEN) - rstart_reg;
    assign wr_idx = start_flag ? 5'd0 :
                    (phase_reg == PH_HEADER) ? pos_reg[4:0] : k_w[4:0];
    assign cur_we = start_flag || (phase_reg == PH_HEADER) ||
                    (phase_reg == PH_FIXED && k_w < 17'(FIXED_LEN));

    always_comb
    begin
        for (int i = 0; i < 26; i++)
        begin
            cur[i] = (cur_we && wr_idx == 5'(i)) ? image_byte : rb_reg[i];
        end
    end

    // Walk step for one accepted item.
    always_comb
    begin
        phase_t      ph;
        logic [16:0] pos, d, rs;
        logic [15:0] dl, ac, rd;
        logic [8:0]  nl;
        logic [2:0]  nf;
        logic        fpv, stop;
        logic [31:0] fp, nxt, dat, pln, cmp;
        logic [32:0] fe, pend;
        logic [16:0] dend;
        logic [20:0] need;
        logic        bad;

        ph = phase_reg; pos = pos_reg; dl = dlen_reg; ac = acnt_reg; rs = rstart_reg;
        nl = nlen_reg; nf = nflag_reg; rd = done_reg; fpv = fpv_reg; fp = fp_reg;
        fe = fend_reg; stop = 1'b0;
        d = '0; dend = '0; need = '0; bad = 1'b0; pend = '0;
        nxt = {cur[3], cur[2], cur[1], cur[0]};
        dat = {cur[9], cur[8], cur[7], cur[6]};
        pln = {cur[17], cur[16], cur[15], cur[14]};
        cmp = {cur[21], cur[20], cur[19], cur[18]};
        res_n = 2'd0; res0 = '0; res1 = '0; rb_we = 1'b0;

        if (fire)
        begin
            // A start byte restarts the walk.
            if (start_flag)
            begin
                ph = PH_HEADER; pos = '0; dl = '0; ac = '0; rs = '0; nl = '0; nf = '0;
                rd = '0; fpv = 1'b0; fp = '0; fe = '0;
                if (span < 32'(MIN_SPAN))
                begin
                    res0 = make_reject(RS_SHORT); res_n = 2'd1; ph = PH_DONE; stop = 1'b1;
                end
            end
            if (!stop)
            begin
                case (ph)
                    PH_HEADER:
                    begin
                        rb_we = 1'b1;
                        pos = pos + 17'd1;
                        if (pos == 17'(HDR_LEN))
                        begin
                            dl = {cur[7], cur[6]};
                            ac = {cur[11], cur[10]};
                            need = 21'(ac) * 21'(MIN_REC);
                            res_n = 2'd1; ph = PH_DONE;
                            if ({cur[5], cur[4]} != HDR_TAG) res0 = make_reject(RS_TAG);
                            else if (dl == 16'd0) res0 = make_reject(RS_DIRZERO);
                            else if (ac == 16'd0 || need > 21'(dl)) res0 = make_reject(RS_COUNT);
                            else if (33'(dl) + 33'(HDR_LEN) > {1'b0, span})
                                res0 = make_reject(RS_OVERFLOW);
                            else
                            begin
                                res_n = 2'd0; ph = PH_FIXED;
                                fe = 33'(dl) + 33'(HDR_LEN); rs = '0;
                            end
                        end
                    end
                    PH_FIXED, PH_NAME:
                    begin
                        d = pos - 17'(HDR_LEN);
                        pos = pos + 17'd1;
                        if (d >= 17'(dl))
                        begin
                            res0 = make_summary(rd, fpv, fp, dl, fe, span);
                            res_n = 2'd1; ph = PH_DONE;
                        end
                        else if (ph == PH_FIXED)
                        begin
                            if (k_w >= 17'(FIXED_LEN))
                            begin
                                res0 = make_summary(rd, fpv, fp, dl, fe, span);
                                res_n = 2'd1; ph = PH_DONE;
                            end
                            else
                            begin
                                rb_we = 1'b1;
                                if (k_w == 17'(FIXED_LEN - 1))
                                begin
                                    if (cur[24] != 8'd1 || cur[25] > 8'd1 || nxt[31] ||
                                        dat[31] || pln[31] || cmp[31] || cmp < 32'd5)
                                    begin
                                        res0 = make_summary(rd, fpv, fp, dl, fe, span);
                                        res_n = 2'd1; ph = PH_DONE;
                                    end
                                    else
                                    begin
                                        nl = '0; nf = '0; ph = PH_NAME;
                                    end
                                end
                            end
                        end
                        else if (image_byte == 8'd0)
                        begin
                            // Name terminator: record checks, then the member result.
                            dend = 17'(dl) + 17'(HDR_LEN);
                            res_n = 2'd1; ph = PH_DONE;
                            if (nl == 9'd0)
                                res0 = make_summary(rd, fpv, fp, dl, fe, span);
                            else if ({1'b0, nxt} != 33'(d) + 33'(HDR_LEN + 1))
                                res0 = make_reject(RS_CHAIN);
                            else if (dat > span || cmp > span - dat)
                                res0 = make_reject(RS_RANGE);
                            else if (dat < 32'(dend))
                                res0 = make_reject(RS_INDIR);
                            else if (nf[0] || (nl == 9'd2 && nf[2:1] == 2'b11))
                                res0 = make_reject(RS_NAME);
                            else
                            begin
                                if (!fpv)
                                begin
                                    fpv = 1'b1; fp = dat;
                                end
                                res0.status = ST_MEMBER;
                                res0.member_count = rd;
                                res0.record_offset = 33'(base) + 33'(HDR_LEN) + 33'(rs);
                                res0.record_length = 9'(FIXED_LEN + 1) + nl;
                                res0.payload_offset = 33'(base) + 33'(dat) + 33'd4;
                                res0.packed_size = 31'(cmp - 32'd4);
                                res0.unpacked_size = pln[30:0];
                                res0.method_byte = cur[25][0];
                                res0.timestamp = {cur[13], cur[12], cur[11], cur[10]};
                                pend = 33'(dat) + 33'(cmp);
                                if (pend > fe) fe = pend;
                                rd = rd + 16'd1;
                                rs = d + 17'd1;
                                ph = PH_FIXED;
                                if (rd >= ac || 18'(rs) + 18'(FIXED_LEN) > 18'(dl))
                                begin
                                    res1 = make_summary(rd, fpv, fp, dl, fe, span);
                                    res_n = 2'd2; ph = PH_DONE;
                                end
                            end
                        end
                        else
                        begin
                            // Name character.
                            nl = nl + 9'd1;
                            bad = image_byte < 8'h20 || image_byte > 8'h7E ||
                                  image_byte == "/" || image_byte == "\\" ||
                                  image_byte == ":" || image_byte == "*" ||
                                  image_byte == "?" || image_byte == "\"" ||
                                  image_byte == "<" || image_byte == ">" ||
                                  image_byte == "|";
                            if (bad) nf[0] = 1'b1;
                            if (image_byte == "." && nl == 9'd1) nf[1] = 1'b1;
                            if (image_byte == "." && nl == 9'd2) nf[2] = 1'b1;
                            if (nl > 9'(MAX_NAME_LENGTH) || d + 17'd1 >= 17'(dl))
                            begin
                                res0 = make_summary(rd, fpv, fp, dl, fe, span);
                                res_n = 2'd1; ph = PH_DONE;
                            end
                        end
                    end
                    default:
                    begin
                        ph = ph;
                    end
                endcase
            end
        end

        phase_next = ph; pos_next = pos; dlen_next = dl; acnt_next = ac; rstart_next = rs;
        nlen_next = nl; nflag_next = nf; done_next = rd; fpv_next = fpv; fp_next = fp;
        fend_next = fe;
    end

    // Walk state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            dlen_reg   <= '0;
            acnt_reg   <= '0;
            rstart_reg <= '0;
            nlen_reg   <= '0;
            nflag_reg  <= '0;
            done_reg   <= '0;
            fpv_reg    <= 1'b0;
            fp_reg     <= '0;
            fend_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            dlen_reg   <= dlen_next;
            acnt_reg   <= acnt_next;
            rstart_reg <= rstart_next;
            nlen_reg   <= nlen_next;
            nflag_reg  <= nflag_next;
            done_reg   <= done_next;
            fpv_reg    <= fpv_next;
            fp_reg     <= fp_next;
            fend_reg   <= fend_next;
        end
    end

    // Header and record byte store.
    always_ff @(posedge clk)
    begin
        if (rb_we && wr_idx < 5'(FIXED_LEN))
        begin
            rb_reg[wr_idx] <= image_byte;
        end
    end

endmodule

// ===== rtl/adw_check.sv =====
// ----------------------------------------------------------------------------
// adw_check
// Port-level checks on the directory walker, bound to the top level.
// ----------------------------------------------------------------------------
module adw_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [15:0] member_count,
    input logic [31:0] image_extent,
    input logic        last_result
);
    import adw_pkg::*;

    // Input is only held off while results are waiting.
    a_stall_has_items: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid) else $error("input stalled with empty queue");

    // A reject always closes the image.
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_REJECT |-> last_result && member_count == 16'd0)
        else $error("reject not final or carries a count");

    // Member items carry no image extent and never close the image.
    a_member_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_MEMBER |-> image_extent == 32'd0 && !last_result)
        else $error("member item with summary fields");

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result withdrawn");

endmodule

bind archive_directory_walker_unit adw_check u_adw_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .member_count (member_count),
    .image_extent (image_extent),
    .last_result  (last_result)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the archive directory walker.
// Disk images are built byte by byte, mostly well formed with random
// content and some with a single planted flaw. A directory walk model
// predicts every member, summary and reject item, and a monitor compares
// each accepted result item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import adw_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 400;

    // Kinds of damage planted in a generated image.
    typedef enum int {
        CR_NONE, CR_TAG, CR_DIRZERO, CR_COUNTZERO, CR_COUNTBIG, CR_OVERFLOW,
        CR_CHAIN, CR_RANGE, CR_INDIR, CR_BADNAME, CR_DOTDOT, CR_EMPTY, CR_DISK,
        CR_METHOD, CR_NEG, CR_COMPSMALL, CR_UNTERM, CR_ADJ, CR_NOISE, CR_TRUNC
    } flaw_t;

    typedef struct {
        bit [7:0] value;
        bit       first;
    } image_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  image_byte = '0;
    logic        start_flag = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [3:0]  reason;
    logic [15:0] member_count;
    logic [32:0] record_offset;
    logic [8:0]  record_length;
    logic [32:0] payload_offset;
    logic [30:0] packed_size;
    logic [30:0] unpacked_size;
    logic        method_byte;
    logic [31:0] timestamp;
    logic [31:0] image_extent;
    logic        last_result;

    image_byte_t image_bytes_q[$];
    result_t     pending_results[$];
    bit [7:0]    img_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          hold_order = 0;

    // Walk model state.
    bit [31:0]       span_r = '0;
    bit [31:0]       base_r = '0;
    int unsigned     pos_r, dlen_r, count_r, rstart_r, nlen_r, nflags_r, ndone_r;
    phase_t          phase_r = PH_IDLE;
    bit [7:0]        rec_r[32];
    longint unsigned first_pay_r, furthest_r;
    bit              first_pay_ok;

    archive_directory_walker_unit dut (.*);

    always #10 clk = ~clk;

    // Little-endian field from the captured header or record bytes.
    function automatic longint unsigned rec_field(int k, int n);
        longint unsigned v = 0;
        for (int j = n - 1; j >= 0; j--)
            v = (v << 8) | rec_r[k + j];
        return v;
    endfunction

    task automatic reject_image(input logic [3:0] why);
        result_t r = '0;
        r.status = ST_REJECT;
        r.reason = why;
        r.last_result = 1'b1;
        pending_results.push_back(r);
        phase_r = PH_DONE;
    endtask

    task automatic close_walk();
        result_t r = '0;
        longint unsigned spanl = span_r;
        if (ndone_r == 0)
            reject_image(RS_EMPTY);
        else if (!first_pay_ok || first_pay_r != HDR_LEN + dlen_r)
            reject_image(RS_ADJACENT);
        else
        begin
            r.status = ST_SUMMARY;
            r.member_count = ndone_r[15:0];
            r.image_extent = (furthest_r < spanl) ? furthest_r[31:0] : span_r;
            r.last_result = 1'b1;
            pending_results.push_back(r);
            phase_r = PH_DONE;
        end
    endtask

    // Checks run at a name terminator; a good record yields a member item.
    task automatic accept_record(input int unsigned d);
        result_t r = '0;
        longint unsigned nxt = rec_field(0, 4);
        longint unsigned dat = rec_field(6, 4);
        longint unsigned pln = rec_field(14, 4);
        longint unsigned cmp = rec_field(18, 4);
        longint unsigned spanl = span_r;
        if (nxt != HDR_LEN + d + 1)
            reject_image(RS_CHAIN);
        else if (!(dat <= spanl && cmp <= spanl - dat))
            reject_image(RS_RANGE);
        else if (dat < HDR_LEN + dlen_r)
            reject_image(RS_INDIR);
        else if (nflags_r[0] || (nlen_r == 2 && nflags_r[2:1] == 2'b11))
            reject_image(RS_NAME);
        else
        begin
            if (!first_pay_ok)
            begin
                first_pay_ok = 1'b1;
                first_pay_r = dat;
            end
            r.status = ST_MEMBER;
            r.member_count = ndone_r[15:0];
            r.record_offset = base_r + HDR_LEN + rstart_r;
            r.record_length = FIXED_LEN + nlen_r + 1;
            r.payload_offset = base_r + dat + 4;
            r.packed_size = cmp - 4;
            r.unpacked_size = pln;
            r.method_byte = rec_r[25][0];
            // Date in bytes 12 and 13 above time in bytes 10 and 11.
            r.timestamp = rec_field(10, 4);
            pending_results.push_back(r);
            if (dat + cmp > furthest_r)
                furthest_r = dat + cmp;
            ndone_r = (ndone_r + 1) & 16'hFFFF;
            rstart_r = d + 1;
            if (ndone_r >= count_r || rstart_r + FIXED_LEN > dlen_r)
                close_walk();
            else
                phase_r = PH_FIXED;
        end
    endtask

    // Advances the walk model by one accepted item.
    task automatic walk_byte(input bit [7:0] b, input bit s);
        int unsigned d, k;
        longint unsigned spanl = span_r;
        if (s)
        begin
            pos_r = 0; dlen_r = 0; count_r = 0; rstart_r = 0;
            nlen_r = 0; nflags_r = 0; ndone_r = 0;
            foreach (rec_r[j]) rec_r[j] = '0;
            first_pay_r = 0; first_pay_ok = 1'b0; furthest_r = 0;
            phase_r = PH_HEADER;
            if (span_r < MIN_SPAN)
            begin
                reject_image(RS_SHORT);
                return;
            end
        end
        if (phase_r != PH_HEADER && phase_r != PH_FIXED && phase_r != PH_NAME)
            return;

        if (phase_r == PH_HEADER)
        begin
            rec_r[pos_r] = b;
            pos_r++;
            if (pos_r < HDR_LEN)
                return;
            dlen_r = rec_field(6, 2);
            count_r = rec_field(10, 2);
            if (rec_field(4, 2) != HDR_TAG)
                reject_image(RS_TAG);
            else if (dlen_r == 0)
                reject_image(RS_DIRZERO);
            else if (count_r < 1 || count_r * MIN_REC > dlen_r)
                reject_image(RS_COUNT);
            else if (dlen_r > spanl - HDR_LEN)
                reject_image(RS_OVERFLOW);
            else
            begin
                furthest_r = HDR_LEN + dlen_r;
                rstart_r = 0;
                phase_r = PH_FIXED;
            end
            return;
        end

        d = pos_r - HDR_LEN;
        pos_r = (pos_r + 1) & 17'h1FFFF;
        if (d >= dlen_r)
        begin
            close_walk();
            return;
        end

        if (phase_r == PH_FIXED)
        begin
            k = d - rstart_r;
            if (k >= FIXED_LEN)
            begin
                close_walk();
                return;
            end
            rec_r[k] = b;
            if (k < FIXED_LEN - 1)
                return;
            if (rec_r[24] != 8'd1 || rec_r[25] > 8'd1 || rec_r[3][7] || rec_r[9][7]
                || rec_r[17][7] || rec_r[21][7] || rec_field(18, 4) < 5)
                close_walk();
            else
            begin
                nlen_r = 0;
                nflags_r = 0;
                phase_r = PH_NAME;
            end
            return;
        end

        // Name bytes up to the terminator.
        if (b == 8'd0)
        begin
            if (nlen_r == 0)
                close_walk();
            else
                accept_record(d);
            return;
        end
        nlen_r++;
        if (nlen_r > 255)
        begin
            close_walk();
            return;
        end
        if (b < 8'h20 || b > 8'h7E || b == "/" || b == "\\" || b == ":" || b == "*"
            || b == "?" || b == "\"" || b == "<" || b == ">" || b == "|")
            nflags_r[0] = 1'b1;
        if (b == "." && nlen_r == 1)
            nflags_r[1] = 1'b1;
        if (b == "." && nlen_r == 2)
            nflags_r[2] = 1'b1;
        if (d + 1 >= dlen_r)
            close_walk();
    endtask

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    // Cycle limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("archive_directory_walker_unit test failed");
            $finish;
        end
    end

    // Sender: offers queued bytes with random gaps.
    int send_gap = 0;
    bit send_calm = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        image_byte_t nxt;
        bit          vld;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            vld = in_valid;
            if (in_valid && in_ready)
            begin
                walk_byte(image_byte, start_flag);
                vld = 1'b0;
            end
            if (!vld)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (image_bytes_q.size() > 0)
                begin
                    nxt = image_bytes_q.pop_front();
                    image_byte <= nxt.value;
                    start_flag <= nxt.first;
                    vld = 1'b1;
                    if ($urandom_range(0, 40) == 0)
                        send_calm = !send_calm;
                    send_gap = draw_gap(send_calm);
                end
            end
            in_valid <= vld;
        end
    end

    task automatic check_field(input string nm, input logic [32:0] e, input logic [32:0] a);
        if (a !== e)
        begin
            errors++;
            $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, nm, e, a);
        end
    endtask

    // Receiver: random stalls, one long hold on request, checks each result.
    int recv_wait = 0;
    int hold_left = 0;
    int hold_taken = 0;
    bit recv_calm = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result item, status %0d reason %0d",
                             $realtime, status, reason);
                end
                else
                begin
                    e = pending_results.pop_front();
                    check_field("status", e.status, status);
                    check_field("reason", e.reason, reason);
                    check_field("member_count", e.member_count, member_count);
                    check_field("record_offset", e.record_offset, record_offset);
                    check_field("record_length", e.record_length, record_length);
                    check_field("payload_offset", e.payload_offset, payload_offset);
                    check_field("packed_size", e.packed_size, packed_size);
                    check_field("unpacked_size", e.unpacked_size, unpacked_size);
                    check_field("method_byte", e.method_byte, method_byte);
                    check_field("timestamp", e.timestamp, timestamp);
                    check_field("image_extent", e.image_extent, image_extent);
                    check_field("last_result", e.last_result, last_result);
                end
                if ($urandom_range(0, 30) == 0)
                    recv_calm = !recv_calm;
                recv_wait = draw_gap(recv_calm);
            end
            if (hold_taken != hold_order)
            begin
                hold_taken = hold_order;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_SPAN)
            span_r = val;
        else
            base_r = val;
        cfg_valid <= 1'b0;
    endtask

    // Waits until every byte is taken and every result has arrived.
    task automatic drain();
        while (image_bytes_q.size() > 0 || in_valid || pending_results.size() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic queue_byte(input bit [7:0] v, input bit s);
        image_byte_t it;
        it.value = v;
        it.first = s;
        image_bytes_q.push_back(it);
    endtask

    task automatic put32(input bit [31:0] v);
        for (int j = 0; j < 4; j++)
            img_q.push_back(v[8*j +: 8]);
    endtask

    // Builds one image, plants the given flaw and queues it.
    task automatic build_image(input flaw_t kind);
        int n, dl, extra, dptr, rs, ro, cmp, ri, cut;
        int nl[2];
        int roff[2];
        int negpos[4] = '{3, 9, 17, 21};
        bit [7:0] bad[8] = '{8'h3A, 8'h2F, 8'h1F, 8'h7F, 8'h80, 8'h2A, 8'h7C, 8'hFF};
        img_q.delete();
        n = $urandom_range(1, 2);
        dl = 0;
        for (int i = 0; i < n; i++)
        begin
            nl[i] = $urandom_range(1, 5);
            if (kind == CR_DOTDOT && i == 0)
                nl[i] = 2;
            dl += FIXED_LEN + 1 + nl[i];
        end
        extra = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        dl += extra;

        // Header.
        for (int j = 0; j < HDR_LEN; j++)
            img_q.push_back($urandom);
        img_q[4] = HDR_TAG[7:0];
        img_q[5] = HDR_TAG[15:8];
        img_q[6] = dl[7:0];
        img_q[7] = dl[15:8];
        img_q[10] = n + ((extra > 0) ? $urandom_range(0, 1) : 0);
        img_q[11] = 8'd0;

        // Records chained back to back, payloads packed behind the directory.
        dptr = HDR_LEN + dl;
        rs = 0;
        for (int i = 0; i < n; i++)
        begin
            roff[i] = img_q.size();
            cmp = $urandom_range(5, 60);
            put32(HDR_LEN + rs + FIXED_LEN + 1 + nl[i]);
            img_q.push_back($urandom);
            img_q.push_back($urandom);
            put32(dptr);
            put32($urandom);
            put32($urandom & 32'h7FFF_FFFF);
            put32(cmp);
            img_q.push_back($urandom);
            img_q.push_back($urandom);
            img_q.push_back(8'd1);
            img_q.push_back($urandom_range(0, 1));
            for (int j = 0; j < nl[i]; j++)
                img_q.push_back(($urandom_range(0, 7) == 0) ? "."
                                                            : 8'h61 + $urandom_range(0, 25));
            img_q.push_back(8'd0);
            dptr += cmp;
            rs += FIXED_LEN + 1 + nl[i];
        end
        for (int j = 0; j < extra; j++)
            img_q.push_back($urandom);

        ri = (kind == CR_DOTDOT || kind == CR_ADJ) ? 0 : $urandom_range(0, n - 1);
        ro = roff[ri];
        case (kind)
            CR_TAG:       img_q[4 + $urandom_range(0, 1)] ^= 8'd1 << $urandom_range(0, 7);
            CR_DIRZERO:   begin img_q[6] = 0; img_q[7] = 0; end
            CR_COUNTZERO: begin img_q[10] = 0; img_q[11] = 0; end
            CR_COUNTBIG:  img_q[11] = $urandom_range(1, 255);
            CR_OVERFLOW:  img_q[7] |= 8'h80;
            CR_CHAIN:     img_q[ro] ^= 8'd1 << $urandom_range(0, 7);
            CR_RANGE:     img_q[ro + 9] = $urandom_range(8'h10, 8'h7F);
            CR_INDIR:     begin img_q[ro + 6] = $urandom_range(0, 20); img_q[ro + 7] = 0;
                              img_q[ro + 8] = 0; img_q[ro + 9] = 0; end
            CR_BADNAME:   img_q[ro + FIXED_LEN] = bad[$urandom_range(0, 7)];
            CR_DOTDOT:    begin img_q[ro + FIXED_LEN] = "."; img_q[ro + FIXED_LEN + 1] = ".";
                          end
            CR_EMPTY:     img_q[ro + FIXED_LEN] = 8'd0;
            CR_DISK:      img_q[ro + 24] = ($urandom_range(0, 1)) ? 8'd0 : $urandom_range(2, 255);
            CR_METHOD:    img_q[ro + 25] = $urandom_range(2, 255);
            CR_NEG:       img_q[ro + negpos[$urandom_range(0, 3)]] |= 8'h80;
            CR_COMPSMALL: begin img_q[ro + 18] = $urandom_range(0, 4); img_q[ro + 19] = 0;
                              img_q[ro + 20] = 0; img_q[ro + 21] = 0; end
            CR_UNTERM:    begin cut = ro - HDR_LEN + FIXED_LEN + $urandom_range(0, nl[ri] - 1);
                              img_q[6] = cut[7:0]; img_q[7] = cut[15:8]; end
            CR_ADJ:       img_q[ro + 6] += $urandom_range(1, 3);
            CR_NOISE:     img_q[$urandom_range(0, img_q.size() - 1)] = $urandom;
            CR_TRUNC:     begin cut = $urandom_range(1, img_q.size() - 1);
                              while (img_q.size() > cut) void'(img_q.pop_back()); end
            default: ;
        endcase

        foreach (img_q[j])
            queue_byte(img_q[j], j == 0);
        repeat ($urandom_range(0, 3))
            queue_byte($urandom, 1'b0);
    endtask

    // Stimulus sequence.
    initial
    begin
        bit [31:0] spans[6];
        bit [31:0] bases[6];
        flaw_t     kind;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: idle bytes are ignored and a short image is refused.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h5A, 1'b1);
        queue_byte(8'hA5, 1'b0);
        queue_byte(8'h0E, 1'b1);
        drain();
        write_reg(CFG_SPAN, 32'd46);
        write_reg(CFG_BASE, 32'hFFFF_FFFF);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h55, 1'b0);
        drain();

        // Directed: a burst of refused images under a long receiver hold
        // fills the result queue and stalls the input.
        hold_order++;
        repeat (12)
            queue_byte($urandom, 1'b1);
        drain();

        // Random images under several register settings.
        spans = '{32'd47, 32'd300, 32'hFFFF_FFFF, 32'd100000,
                  $urandom_range(47, 4000), 32'hFFFF_FFFF};
        bases = '{32'd0, $urandom, 32'hFFFF_FFFF, $urandom, 32'd0, $urandom};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_SPAN, spans[p]);
            write_reg(CFG_BASE, bases[p]);
            for (int i = 0; i < ((p == 2) ? 2 : 1); i++)
            begin
                kind = ($urandom_range(0, 1) == 0) ? flaw_t'($urandom_range(1, CR_TRUNC))
                                                   : CR_NONE;
                build_image(kind);
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("archive_directory_walker_unit test passed");
        else
            $display("archive_directory_walker_unit test failed");
        $finish;
    end

endmodule
